// ===== hw/rtl/dmc_pkg.sv =====
`default_nettype none

package dmc_pkg;

  // Address split and storage sizes
  localparam int unsigned AddrBits     = 10;
  localparam int unsigned WordsPerLine = 8;
  localparam int unsigned LineCount    = 4;
  localparam int unsigned MemBytes     = 1024;
  localparam int unsigned WordBits     = $clog2(WordsPerLine);
  localparam int unsigned LineBits     = $clog2(LineCount);
  localparam int unsigned TagBits      = 5;
  localparam int unsigned MemAddrBits  = $clog2(MemBytes);
  localparam int unsigned ByteBits     = 8;

  // Counters and penalty
  localparam int unsigned CountBits   = 16;
  localparam int unsigned TimeBits    = 32;
  localparam int unsigned PenaltyBits = 8;
  localparam logic [PenaltyBits-1:0] PenaltyReset = 8'd10;

  // Register port
  localparam int unsigned ApbAddrBits = 3;
  localparam int unsigned ApbDataBits = 32;
  localparam int unsigned RegIdxBits  = ApbAddrBits - 2;

  typedef enum logic [RegIdxBits-1:0] {
    RegMissPenalty = 1'b0
  } reg_idx_e;

  typedef enum logic {
    OpLoad   = 1'b0,
    OpAccess = 1'b1
  } op_e;

  // Result word in flight between the lookup and the output register
  typedef struct packed {
    logic                 hit;
    logic                 is_access;
    logic [CountBits-1:0] miss_total;
    logic [CountBits-1:0] access_total;
    logic [TimeBits-1:0]  time_total;
  } stage_t;

  function automatic logic [CountBits-1:0] sat_inc(input logic [CountBits-1:0] a);
    logic [CountBits-1:0] r;
    r = (&a) ? a : a + CountBits'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dmc_ram.sv =====
`default_nettype none

module dmc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/direct_mapped_cache_model_top.sv =====
// Direct-mapped cache model: 4 lines of 8 bytes in front of a 1024-byte backing
// store, reporting hit/miss, the addressed byte and running totals.
// Input channel (in_valid_i / in_stall_o) carries op, address and load byte;
// op load writes one backing byte, op access looks up the line tag and fills
// the tag on a miss. Every input word gives exactly one output word
// (out_valid_o / out_stall_i) in the same order.
// Path: an accepted word is registered in the lookup stage, in step with the
// registered read of the backing store, and then in the output register, which
// drives out_valid_o.
// Throughput: one word per cycle unless the receiver stalls; tag compare and
// counter update are done in the acceptance cycle, so back-to-back accesses to
// one line see each other. On a receiver stall the output word holds; an empty
// lookup stage still takes one input word; in_stall_o rises once it is full.
// Reset clears the line valid bits and all totals and sets the miss penalty
// to 10; the backing store is not cleared, so read only bytes written first.
// The miss penalty register lies at byte address 0 of the APB port; the user
// must write it only while no word is in flight; the block does not enforce it.
`default_nettype none

module direct_mapped_cache_model_top
  import dmc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // input channel
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [0:0]             op_i,
  input  wire logic [AddrBits-1:0]    address_i,
  input  wire logic [ByteBits-1:0]    load_byte_i,
  // output channel
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [0:0]                  hit_o,
  output logic [ByteBits-1:0]         read_byte_o,
  output logic [CountBits-1:0]        miss_total_o,
  output logic [CountBits-1:0]        access_total_o,
  output logic [TimeBits-1:0]         time_total_o,
  // register port
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [ApbAddrBits-1:0] paddr,
  input  wire logic [ApbDataBits-1:0] pwdata,
  output logic      [ApbDataBits-1:0] prdata,
  output logic                        pready
);

  logic [PenaltyBits-1:0] penalty_q;
  logic [TagBits-1:0]     tag_q [LineCount];
  logic [LineCount-1:0]   valid_q;
  logic [CountBits-1:0]   miss_q, miss_d;
  logic [CountBits-1:0]   access_q, access_d;
  logic [TimeBits-1:0]    time_q, time_d;
  logic                   s1_valid_q;
  stage_t                 s1_q, s1_d;
  logic                   out_valid_q;
  logic                   out_hit_q;
  logic [ByteBits-1:0]    out_byte_q;
  logic [CountBits-1:0]   out_miss_q, out_access_q;
  logic [TimeBits-1:0]    out_time_q;

  logic                   in_acc, s1_adv, out_busy;
  logic                   is_access, hit_c, miss_c;
  logic [LineBits-1:0]    line_idx;
  logic [TagBits-1:0]     tag_c;
  logic [TimeBits:0]      time_sum;
  logic [ByteBits-1:0]    ram_rdata;
  reg_idx_e               reg_idx;

  // Handshake: the lookup stage drains into the output register
  assign out_busy   = out_valid_q & out_stall_i;
  assign in_stall_o = s1_valid_q & out_busy;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign s1_adv     = s1_valid_q & ~out_busy;

  // Split the address
  assign line_idx  = address_i[WordBits +: LineBits];
  assign tag_c     = address_i[WordBits + LineBits +: TagBits];
  assign is_access = (op_e'(op_i) == OpAccess);
  assign hit_c     = valid_q[line_idx] & (tag_q[line_idx] == tag_c);
  assign miss_c    = is_access & ~hit_c;

  // Advance totals, saturating
  assign time_sum = {1'b0, time_q} + (TimeBits + 1)'(1)
                  + (miss_c ? (TimeBits + 1)'(penalty_q) : '0);

  always_comb begin
    miss_d   = miss_q;
    access_d = access_q;
    time_d   = time_q;
    if (in_acc && is_access) begin
      access_d = sat_inc(access_q);
      time_d   = time_sum[TimeBits] ? '1 : time_sum[TimeBits-1:0];
      if (!hit_c) begin
        miss_d = sat_inc(miss_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_q   <= '0;
      access_q <= '0;
      time_q   <= '0;
    end else begin
      miss_q   <= miss_d;
      access_q <= access_d;
      time_q   <= time_d;
    end
  end

  // Fill the tag of the addressed line on a miss
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (in_acc && miss_c) begin
      valid_q[line_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && miss_c) begin
      tag_q[line_idx] <= tag_c;
    end
  end

  // Backing store: load writes, every word reads the addressed byte
  dmc_ram #(
    .Width(ByteBits),
    .Depth(MemBytes)
  ) u_backing (
    .clk_i  (clk_i),
    .we_i   (in_acc & ~is_access),
    .waddr_i(address_i[MemAddrBits-1:0]),
    .wdata_i(load_byte_i),
    .re_i   (in_acc),
    .raddr_i(address_i[MemAddrBits-1:0]),
    .rdata_o(ram_rdata)
  );

  // Lookup stage, in step with the store read
  always_comb begin
    s1_d              = '0;
    s1_d.hit          = is_access & hit_c;
    s1_d.is_access    = is_access;
    s1_d.miss_total   = miss_d;
    s1_d.access_total = access_d;
    s1_d.time_total   = time_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_hit_q    <= s1_q.hit;
      out_byte_q   <= s1_q.is_access ? ram_rdata : '0;
      out_miss_q   <= s1_q.miss_total;
      out_access_q <= s1_q.access_total;
      out_time_q   <= s1_q.time_total;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = out_hit_q;
  assign read_byte_o    = out_byte_q;
  assign miss_total_o   = out_miss_q;
  assign access_total_o = out_access_q;
  assign time_total_o   = out_time_q;

  // Register port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[ApbAddrBits-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      penalty_q <= PenaltyReset;
    end else if (psel && penable && pwrite && pready && reg_idx == RegMissPenalty) begin
      penalty_q <= pwdata[PenaltyBits-1:0];
    end
  end

  always_comb begin
    case (reg_idx)
      RegMissPenalty: prdata = ApbDataBits'(penalty_q);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dmc_checker.sv =====
`default_nettype none

module dmc_checker
  import dmc_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire logic [0:0]           hit_o,
  input wire logic [ByteBits-1:0]  read_byte_o,
  input wire logic [CountBits-1:0] miss_total_o,
  input wire logic [CountBits-1:0] access_total_o,
  input wire logic [TimeBits-1:0]  time_total_o
);

  logic                 out_acc;
  logic                 seen_q;
  logic [CountBits-1:0] last_miss_q, last_access_q;

  assign out_acc = out_valid_o & ~out_stall_i;

  // Track totals of the last word taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q        <= 1'b0;
      last_miss_q   <= '0;
      last_access_q <= '0;
    end else if (out_acc) begin
      seen_q        <= 1'b1;
      last_miss_q   <= miss_total_o;
      last_access_q <= access_total_o;
    end
  end

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(hit_o) && $stable(read_byte_o)
      && $stable(miss_total_o) && $stable(access_total_o) && $stable(time_total_o))
    else $error("output word changed while stalled");

  a_miss_le_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> miss_total_o <= access_total_o)
    else $error("more misses than accesses");

  a_access_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q |-> access_total_o >= last_access_q)
    else $error("access total went backwards");

  a_hit_no_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q && hit_o[0] |-> miss_total_o == last_miss_q)
    else $error("miss total moved on a hit");

endmodule

bind direct_mapped_cache_model_top dmc_checker u_dmc_checker (.*);

`default_nettype wire
